>>> hw/rtl/p2sq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2sq_pkg
// Shared types, constants and elaboration-time tables for the pitch to scale
// quantizer: semitone midpoint thresholds, note frequencies and a mod-12 table.
// ----------------------------------------------------------------------------
package p2sq_pkg;

   // fixed-point format and field widths
   localparam int FRAC_BITS    = 16;
   localparam int NOTE_COUNT   = 128;
   localparam int NOTE_W       = 7;
   localparam int FREQ_W       = 32;
   localparam int THRESH_COUNT = NOTE_COUNT - 1;
   // thresholds reach about 2^30 at this fraction width
   localparam int THR_W        = 40;

   // scale geometry
   localparam int PC_COUNT     = 12;
   localparam int ROOT_NOTE    = 60;
   localparam int OCT_SPAN     = 2;
   localparam int BASE_LO_NOTE = ROOT_NOTE - OCT_SPAN * PC_COUNT;
   localparam int BASE_HI_NOTE = ROOT_NOTE + OCT_SPAN * PC_COUNT;
   localparam int WIN_HALF     = PC_COUNT / 2;
   localparam int WIN_SIZE     = 2 * WIN_HALF + 1;

   // configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE_MASK = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_ROOT   = 4'd1;
   localparam logic [PC_COUNT-1:0]    SCALE_MASK_RESET = 12'd2741;
   localparam logic [3:0]             KEY_ROOT_RESET   = 4'd0;

   // quarter-tone ratios 2^(r/24) scaled by RomDen
   localparam logic [63:0] RomDen = 64'd1000000000;
   localparam logic [63:0] QTONE [24] = '{
      64'd1000000000, 64'd1029302237, 64'd1059463094, 64'd1090507733,
      64'd1122462048, 64'd1155352697, 64'd1189207115, 64'd1224053543,
      64'd1259921050, 64'd1296839555, 64'd1334839854, 64'd1373953647,
      64'd1414213562, 64'd1455653183, 64'd1498307077, 64'd1542210825,
      64'd1587401052, 64'd1633915453, 64'd1681792831, 64'd1731073122,
      64'd1781797436, 64'd1834008086, 64'd1887748625, 64'd1943063883
   };

   // settled configuration seen by the datapath
   typedef struct packed {
      logic [PC_COUNT-1:0] mask;
      logic [3:0]          key;
      logic [NOTE_W-1:0]   lo_note;
      logic [NOTE_W-1:0]   hi_note;
      logic                empty;
   } cfg_type;

   typedef logic [THR_W-1:0]  thresh_table_type [THRESH_COUNT];
   typedef logic [FREQ_W-1:0] freq_table_type   [NOTE_COUNT];
   typedef logic [3:0]        mod12_table_type  [256];

   // smallest input that reaches half-step h, rounded up to an integer
   function automatic logic [THR_W-1:0] half_step_thresh(input int h);
      int          d;
      int          sh;
      logic [63:0] q;
      logic [63:0] ip;
      logic [63:0] rem;
      logic [63:0] v;
      d   = h + 6;
      q   = 64'd440 * QTONE[d % 24];
      ip  = q / RomDen;
      rem = q % RomDen;
      sh  = FRAC_BITS + d / 24 - 6;
      v   = (ip << sh) + (((rem << sh) + RomDen - 64'd1) / RomDen);
      return v[THR_W-1:0];
   endfunction

   // note frequency rounded to nearest, saturated to the output width
   function automatic logic [FREQ_W-1:0] note_freq(input int note);
      int          d;
      int          sh;
      logic [63:0] q;
      logic [63:0] ip;
      logic [63:0] rem;
      logic [63:0] v;
      d   = 2 * note + 6;
      q   = 64'd440 * QTONE[d % 24];
      ip  = q / RomDen;
      rem = q % RomDen;
      sh  = FRAC_BITS + d / 24 - 6;
      v   = (ip << sh) + (((rem << sh) + RomDen / 64'd2) / RomDen);
      if (v > 64'hFFFF_FFFF) begin
         return '1;
      end
      return v[FREQ_W-1:0];
   endfunction

   function automatic thresh_table_type build_thresh_table();
      thresh_table_type t;
      for (int n = 0; n < THRESH_COUNT; n++) begin
         t[n] = half_step_thresh(2 * n + 1);
      end
      return t;
   endfunction

   function automatic freq_table_type build_freq_table();
      freq_table_type t;
      for (int n = 0; n < NOTE_COUNT; n++) begin
         t[n] = note_freq(n);
      end
      return t;
   endfunction

   function automatic mod12_table_type build_mod12_table();
      mod12_table_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = 4'(i % PC_COUNT);
      end
      return t;
   endfunction

   localparam thresh_table_type THRESH_TABLE    = build_thresh_table();
   localparam freq_table_type   NOTE_FREQ_TABLE = build_freq_table();
   localparam mod12_table_type  MOD12_TABLE     = build_mod12_table();

endpackage

>>> hw/rtl/p2sq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2sq channel interfaces
// Valid/ready channels for frequency requests, quantized responses and
// configuration register writes.
// ----------------------------------------------------------------------------

// frequency request channel
interface p2sq_req_if;
   logic                        valid;
   logic                        ready;
   logic [p2sq_pkg::FREQ_W-1:0] freq_in;

   modport source (output valid, output freq_in, input ready);
   modport sink   (input valid, input freq_in, output ready);
endinterface

// quantized response channel
interface p2sq_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [p2sq_pkg::FREQ_W-1:0] freq_out;
   logic [p2sq_pkg::NOTE_W-1:0] snapped_note;
   logic [p2sq_pkg::NOTE_W-1:0] detected_note;

   modport source (output valid, output freq_out, output snapped_note,
                   output detected_note, input ready);
   modport sink   (input valid, input freq_out, input snapped_note,
                   input detected_note, output ready);
endinterface

// register write channel
interface p2sq_csr_if;
   logic                             valid;
   logic                             ready;
   logic [p2sq_pkg::CSR_INDEX_W-1:0] reg_index;
   logic [p2sq_pkg::CSR_DATA_W-1:0]  wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

>>> hw/rtl/pitch_to_scale_quantizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitch_to_scale_quantizer_core
// Pipeline: four register stages (threshold compare, note encode, scale snap,
// frequency lookup) between an accepted request beat and its response beat.
// Throughput: one beat per cycle while the response channel is ready.
// Reset clears all stage valid bits, the scale mask to major and key to C.
// ----------------------------------------------------------------------------
module pitch_to_scale_quantizer_core (
   input  logic        clock,
   input  logic        reset,
   p2sq_req_if.sink    req_ch,
   p2sq_rsp_if.source  rsp_ch,
   p2sq_csr_if.sink    csr_ch
);

   localparam int NW = p2sq_pkg::NOTE_W;
   localparam int TC = p2sq_pkg::THRESH_COUNT;

   p2sq_pkg::cfg_type cfg;

   // stage handshake
   logic adv1, adv2, adv3, adv4;
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;

   // stage payloads
   logic [TC-1:0]                 therm_new;
   logic [TC-1:0]                 therm1_ff, therm1_in;
   logic [NW-1:0]                 det_new;
   logic [NW-1:0]                 det2_ff, det2_in;
   logic [NW-1:0]                 snap_new;
   logic [NW-1:0]                 snap3_ff, snap3_in;
   logic [NW-1:0]                 det3_ff, det3_in;
   logic [p2sq_pkg::FREQ_W-1:0]   freq4_ff, freq4_in;
   logic [NW-1:0]                 snap4_ff, snap4_in;
   logic [NW-1:0]                 det4_ff, det4_in;

   // encode and snap helpers
   logic [NW-1:0]                 enc_probe;
   logic [3:0]                    det_pc;
   logic [4:0]                    pc_sum;
   logic [3:0]                    pc;
   logic [7:0]                    win_cu [p2sq_pkg::WIN_SIZE];
   logic [p2sq_pkg::WIN_SIZE-1:0] win_hit;
   logic                          win_found;
   logic [7:0]                    pick_cu;
   logic [7:0]                    lo_bound;
   logic [7:0]                    hi_bound;

   p2sq_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // each stage moves when it is empty or its successor moves
   assign adv4 = !v4_ff || rsp_ch.ready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_ch.ready = adv1;

   // stage 1: compare against every semitone midpoint
   always_comb begin
      for (int n = 0; n < TC; n++) begin
         therm_new[n] = {{(p2sq_pkg::THR_W - p2sq_pkg::FREQ_W){1'b0}}, req_ch.freq_in}
                        >= p2sq_pkg::THRESH_TABLE[n];
      end
   end

   // stage 2: thermometer to note number, one bit per step
   always_comb begin
      det_new   = '0;
      enc_probe = '0;
      for (int b = NW - 1; b >= 0; b--) begin
         enc_probe = det_new + NW'(1 << b);
         if (therm1_ff[enc_probe - NW'(1)]) det_new = enc_probe;
      end
   end

   // stage 3: pitch class of the detected note relative to the key
   assign det_pc   = p2sq_pkg::MOD12_TABLE[8'(det2_ff) + 8'(p2sq_pkg::PC_COUNT) - 8'(cfg.key)];
   assign lo_bound = 8'(cfg.lo_note) + 8'(p2sq_pkg::WIN_HALF);
   assign hi_bound = 8'(cfg.hi_note) + 8'(p2sq_pkg::WIN_HALF);

   // stage 3: scale membership of the notes around the detected one
   always_comb begin
      pc_sum = '0;
      pc     = '0;
      for (int j = 0; j < p2sq_pkg::WIN_SIZE; j++) begin
         win_cu[j] = 8'(det2_ff) + 8'(j);
         pc_sum    = 5'(det_pc) + 5'(j) + 5'(p2sq_pkg::WIN_HALF);
         if (pc_sum >= 5'(2 * p2sq_pkg::PC_COUNT)) begin
            pc = 4'(pc_sum - 5'(2 * p2sq_pkg::PC_COUNT));
         end else if (pc_sum >= 5'(p2sq_pkg::PC_COUNT)) begin
            pc = 4'(pc_sum - 5'(p2sq_pkg::PC_COUNT));
         end else begin
            pc = pc_sum[3:0];
         end
         win_hit[j] = (win_cu[j] >= lo_bound) && (win_cu[j] <= hi_bound) && cfg.mask[pc];
      end
   end

   // nearest hit wins, lower side first on equal distance
   always_comb begin
      pick_cu = 8'(det2_ff) + 8'(p2sq_pkg::WIN_HALF);
      for (int s = p2sq_pkg::WIN_HALF; s >= 0; s--) begin
         if (win_hit[p2sq_pkg::WIN_HALF + s]) pick_cu = win_cu[p2sq_pkg::WIN_HALF + s];
         if (win_hit[p2sq_pkg::WIN_HALF - s]) pick_cu = win_cu[p2sq_pkg::WIN_HALF - s];
      end
   end

   assign win_found = |win_hit;

   // stage 3: clamp to the ends of the scale span, empty scale passes through
   always_comb begin
      if (cfg.empty) begin
         snap_new = det2_ff;
      end else if (det2_ff <= cfg.lo_note) begin
         snap_new = cfg.lo_note;
      end else if (det2_ff >= cfg.hi_note) begin
         snap_new = cfg.hi_note;
      end else begin
         snap_new = NW'(pick_cu - 8'(p2sq_pkg::WIN_HALF));
      end
   end

   // next-state for valids and payloads
   always_comb begin
      v1_in     = adv1 ? req_ch.valid : v1_ff;
      v2_in     = adv2 ? v1_ff : v2_ff;
      v3_in     = adv3 ? v2_ff : v3_ff;
      v4_in     = adv4 ? v3_ff : v4_ff;
      therm1_in = (adv1 && req_ch.valid) ? therm_new : therm1_ff;
      det2_in   = (adv2 && v1_ff) ? det_new : det2_ff;
      snap3_in  = (adv3 && v2_ff) ? snap_new : snap3_ff;
      det3_in   = (adv3 && v2_ff) ? det2_ff : det3_ff;
      freq4_in  = (adv4 && v3_ff) ? p2sq_pkg::NOTE_FREQ_TABLE[snap3_ff] : freq4_ff;
      snap4_in  = (adv4 && v3_ff) ? snap3_ff : snap4_ff;
      det4_in   = (adv4 && v3_ff) ? det3_ff : det4_ff;
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      therm1_ff <= therm1_in;
      det2_ff   <= det2_in;
      snap3_ff  <= snap3_in;
      det3_ff   <= det3_in;
      freq4_ff  <= freq4_in;
      snap4_ff  <= snap4_in;
      det4_ff   <= det4_in;
   end

   // response beat comes straight from the last stage
   assign rsp_ch.valid         = v4_ff;
   assign rsp_ch.freq_out      = freq4_ff;
   assign rsp_ch.snapped_note  = snap4_ff;
   assign rsp_ch.detected_note = det4_ff;

   // thresholds rise, so the compare vector is a thermometer
   a_therm_shape: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> (((therm1_ff >> 1) & ~therm1_ff) == '0))
      else $error("threshold compare vector is not a thermometer");

   // inside the scale span some scale note lies within half an octave
   a_window_hit: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !cfg.empty && (det2_ff > cfg.lo_note) && (det2_ff < cfg.hi_note)
      |-> win_found)
      else $error("no scale note found near detected note");

   // an accepted request beat lands in stage 1
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> v1_ff)
      else $error("accepted request beat lost at stage 1");

   // a stalled snap stage keeps its item
   a_snap_hold: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !adv3 |=> v3_ff && $stable(snap3_ff) && $stable(det3_ff))
      else $error("stalled snap stage changed");

endmodule

>>> hw/rtl/p2sq_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2sq_csr
// Scale mask and key registers, plus the lowest and highest scale notes that
// the five-octave spread of the mask can reach.
// ----------------------------------------------------------------------------
module p2sq_csr (
   input  logic                 clock,
   input  logic                 reset,
   p2sq_csr_if.sink             csr_ch,
   output p2sq_pkg::cfg_type    cfg
);

   logic [p2sq_pkg::PC_COUNT-1:0] mask_ff, mask_in;
   logic [3:0]                    key_ff, key_in;
   logic [3:0]                    first_pc;
   logic [3:0]                    last_pc;

   // writes are always taken
   assign csr_ch.ready = 1'b1;

   // register decode, out-of-range keys are dropped
   always_comb begin
      mask_in = mask_ff;
      key_in  = key_ff;
      if (csr_ch.valid) begin
         case (csr_ch.reg_index)
            p2sq_pkg::REG_SCALE_MASK: mask_in = csr_ch.wdata[p2sq_pkg::PC_COUNT-1:0];
            p2sq_pkg::REG_KEY_ROOT: begin
               if (csr_ch.wdata[3:0] < 4'(p2sq_pkg::PC_COUNT)) begin
                  key_in = csr_ch.wdata[3:0];
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= p2sq_pkg::SCALE_MASK_RESET;
         key_ff  <= p2sq_pkg::KEY_ROOT_RESET;
      end else begin
         mask_ff <= mask_in;
         key_ff  <= key_in;
      end
   end

   // lowest and highest set interval of the mask
   always_comb begin
      first_pc = '0;
      last_pc  = '0;
      for (int i = p2sq_pkg::PC_COUNT - 1; i >= 0; i--) begin
         if (mask_ff[i]) first_pc = 4'(i);
      end
      for (int i = 0; i < p2sq_pkg::PC_COUNT; i++) begin
         if (mask_ff[i]) last_pc = 4'(i);
      end
   end

   // scale span over octaves -2..+2 around the root
   always_comb begin
      cfg.mask    = mask_ff;
      cfg.key     = key_ff;
      cfg.lo_note = 7'(p2sq_pkg::BASE_LO_NOTE) + 7'(key_ff) + 7'(first_pc);
      cfg.hi_note = 7'(p2sq_pkg::BASE_HI_NOTE) + 7'(key_ff) + 7'(last_pc);
      cfg.empty   = (mask_ff == '0);
   end

endmodule

>>> bench/pitch_to_scale_quantizer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitch_to_scale_quantizer_core_test
// Self-checking bench for the pitch to scale quantizer. A short table of
// frequencies (range ends, exact notes, a midpoint tie) runs at the reset
// scale. Random phases follow, each under a new scale mask and key: empty,
// full and single-note masks and both key extremes, plus ignored key and
// index writes. Each response beat is checked against its pinned result or
// a bench-side model of note detection, scale snapping and note frequency.
// Responses stall in random bursts but in the last phase, requests in most phases.
// ----------------------------------------------------------------------------
module pitch_to_scale_quantizer_core_test;

   localparam int  FREQ_W        = p2sq_pkg::FREQ_W;
   localparam int  NOTE_W        = p2sq_pkg::NOTE_W;
   localparam int  PC_COUNT      = p2sq_pkg::PC_COUNT;
   localparam int  CSR_INDEX_W   = p2sq_pkg::CSR_INDEX_W;
   localparam int  CSR_DATA_W    = p2sq_pkg::CSR_DATA_W;
   localparam int  NOTE_TOP      = p2sq_pkg::NOTE_COUNT - 1;
   localparam int  KEY_COUNT     = 12;
   localparam int  KEY_FIELD_MAX = 15;
   localparam int  INDEX_MAX     = (1 << CSR_INDEX_W) - 1;
   localparam int  TONE_ROWS     = 16;
   localparam int  PHASES        = 9;
   localparam int  PHASE_BEATS   = 180;
   localparam int  QUIET_BEATS   = 100;
   localparam int  TAIL_CYCLES   = 12;
   localparam longint unsigned RATIO_DEN = 64'd1000000000;

   // 2^(r/24) in units of 1e-9
   localparam longint unsigned QUARTER_TONE [24] = '{
      64'd1000000000, 64'd1029302237, 64'd1059463094, 64'd1090507733,
      64'd1122462048, 64'd1155352697, 64'd1189207115, 64'd1224053543,
      64'd1259921050, 64'd1296839555, 64'd1334839854, 64'd1373953647,
      64'd1414213562, 64'd1455653183, 64'd1498307077, 64'd1542210825,
      64'd1587401052, 64'd1633915453, 64'd1681792831, 64'd1731073122,
      64'd1781797436, 64'd1834008086, 64'd1887748625, 64'd1943063883
   };

   typedef struct {
      logic [FREQ_W-1:0] freq_out;
      logic [NOTE_W-1:0] snapped;
      logic [NOTE_W-1:0] detected;
   } quant_result_type;

   typedef struct {
      logic [FREQ_W-1:0] freq;
      bit                pinned;
      logic [FREQ_W-1:0] freq_out;
      logic [NOTE_W-1:0] snapped;
      logic [NOTE_W-1:0] detected;
   } tone_row_type;

   // directed frequencies; pinned rows carry results read straight off the
   // note math (A3, A4, A5 and the midpoint between A4 and A#4)
   tone_row_type tone_rows [TONE_ROWS] = '{
      '{32'd0,          1'b0, 32'd0,        7'd0,  7'd0},
      '{32'd1,          1'b0, 32'd0,        7'd0,  7'd0},
      '{32'hFFFF_FFFF,  1'b0, 32'd0,        7'd0,  7'd0},
      '{32'h8000_0000,  1'b0, 32'd0,        7'd0,  7'd0},
      '{32'd28835840,   1'b1, 32'd28835840, 7'd69, 7'd69},
      '{32'd57671680,   1'b1, 32'd57671680, 7'd81, 7'd81},
      '{32'd14417920,   1'b1, 32'd14417920, 7'd57, 7'd57},
      '{32'd29680795,   1'b1, 32'd28835840, 7'd69, 7'd70},
      '{32'd29680794,   1'b1, 32'd28835840, 7'd69, 7'd69},
      '{32'h0000_FFFF,  1'b0, 32'd0,        7'd0,  7'd0},
      '{32'h5555_5555,  1'b0, 32'd0,        7'd0,  7'd0},
      '{32'hAAAA_AAAA,  1'b0, 32'd0,        7'd0,  7'd0},
      '{32'h0001_0000,  1'b0, 32'd0,        7'd0,  7'd0},
      '{32'd535809,     1'b0, 32'd0,        7'd0,  7'd0},
      '{32'd822083584,  1'b0, 32'd0,        7'd0,  7'd0},
      '{32'hFFFF_0000,  1'b0, 32'd0,        7'd0,  7'd0}
   };

   logic clock = 1'b0;
   logic reset;

   p2sq_req_if req_bus ();
   p2sq_rsp_if rsp_bus ();
   p2sq_csr_if csr_bus ();

   pitch_to_scale_quantizer_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // mirrored registers, pending responses and bookkeeping
   logic [PC_COUNT-1:0] scale_mask_now;
   logic [3:0]          key_root_now;
   quant_result_type    due_notes [$];
   quant_result_type    pinned_result;
   logic                pinned_valid;
   bit                  quiet;
   int                  send_gap_odds;
   int                  ready_hold;
   int                  mismatch_count;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // note model
   // ---------------------------------------------------------------------

   // half-step h as integer part, remainder over RATIO_DEN and shift
   function automatic void split_half_step(input int unsigned h,
                                           output longint unsigned ip,
                                           output longint unsigned rem,
                                           output int unsigned sh);
      int unsigned     d;
      longint unsigned q;
      d   = h + 6;
      q   = 64'd440 * QUARTER_TONE[d % 24];
      ip  = q / RATIO_DEN;
      rem = q % RATIO_DEN;
      sh  = p2sq_pkg::FRAC_BITS + d / 24 - 6;
   endfunction

   function automatic bit reaches_half_step(input longint unsigned f,
                                            input int unsigned h);
      longint unsigned ip;
      longint unsigned rem;
      longint unsigned whole;
      longint unsigned frac;
      int unsigned     sh;
      split_half_step(h, ip, rem, sh);
      whole = f >> sh;
      frac  = f & ((64'd1 << sh) - 64'd1);
      if (whole != ip) begin
         return whole > ip;
      end
      return frac * RATIO_DEN >= (rem << sh);
   endfunction

   // smallest input value that reaches half-step h
   function automatic logic [FREQ_W-1:0] half_step_floor(input int unsigned h);
      longint unsigned ip;
      longint unsigned rem;
      int unsigned     sh;
      split_half_step(h, ip, rem, sh);
      return FREQ_W'((ip << sh) + ((rem << sh) + RATIO_DEN - 64'd1) / RATIO_DEN);
   endfunction

   // note frequency, rounded half up and saturated
   function automatic logic [FREQ_W-1:0] note_value(input int unsigned note);
      longint unsigned ip;
      longint unsigned rem;
      longint unsigned v;
      int unsigned     sh;
      split_half_step(2 * note, ip, rem, sh);
      v = (ip << sh) + ((rem << sh) + RATIO_DEN / 64'd2) / RATIO_DEN;
      return (v > 64'hFFFF_FFFF) ? '1 : FREQ_W'(v);
   endfunction

   function automatic quant_result_type quantize_pitch(input logic [FREQ_W-1:0] f);
      quant_result_type r;
      int               det;
      int               best;
      int               best_diff;
      int               cand;
      int               diff;
      det = 0;
      for (int n = 0; n < NOTE_TOP; n++) begin
         if (reaches_half_step(longint'(f), 2 * n + 1)) begin
            det = n + 1;
         end
      end
      // nearest scale note over five octaves, lower note wins a tie
      best      = det;
      best_diff = p2sq_pkg::NOTE_COUNT;
      for (int oct = -p2sq_pkg::OCT_SPAN; oct <= p2sq_pkg::OCT_SPAN; oct++) begin
         for (int i = 0; i < PC_COUNT; i++) begin
            cand = p2sq_pkg::ROOT_NOTE + int'(key_root_now) + oct * PC_COUNT + i;
            if (scale_mask_now[i] && cand >= 0 && cand <= NOTE_TOP) begin
               diff = (cand > det) ? cand - det : det - cand;
               if (diff < best_diff) begin
                  best      = cand;
                  best_diff = diff;
               end
            end
         end
      end
      r.freq_out = note_value(best);
      r.snapped  = NOTE_W'(best);
      r.detected = NOTE_W'(det);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [FREQ_W-1:0] got,
                                  input logic [FREQ_W-1:0] want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // queue the expected result on each request beat, check each response beat
   always @(posedge clock) begin : beat_check
      quant_result_type want;
      if (!reset) begin
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            due_notes.insert(due_notes.size(),
                             pinned_valid ? pinned_result
                                          : quantize_pitch(req_bus.freq_in));
         end
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (due_notes.size() == 0) begin
               report_mismatch("unexpected beat freq_out", rsp_bus.freq_out, '0);
            end else begin
               want = due_notes.pop_front();
               if (rsp_bus.freq_out !== want.freq_out)
                  report_mismatch("freq_out", rsp_bus.freq_out, want.freq_out);
               if (rsp_bus.snapped_note !== want.snapped)
                  report_mismatch("snapped_note", FREQ_W'(rsp_bus.snapped_note),
                                  FREQ_W'(want.snapped));
               if (rsp_bus.detected_note !== want.detected)
                  report_mismatch("detected_note", FREQ_W'(rsp_bus.detected_note),
                                  FREQ_W'(want.detected));
            end
         end
      end
   end

   // response back-pressure: random stall bursts between open runs
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_bus.ready <= 1'b1;
         ready_hold    <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_bus.ready <= 1'b0;
         ready_hold    <= $urandom_range(0, 17);
      end else begin
         rsp_bus.ready <= 1'b1;
         ready_hold    <= $urandom_range(0, 40);
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------

   // leaves valid high; the caller lowers it after the last beat
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.wdata     <= data;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      if (idx == p2sq_pkg::REG_SCALE_MASK) begin
         scale_mask_now = data[PC_COUNT-1:0];
      end else if (idx == p2sq_pkg::REG_KEY_ROOT && data[3:0] < KEY_COUNT) begin
         key_root_now = data[3:0];
      end
   endtask

   // one request beat, with an optional idle burst ahead of it
   task automatic send_freq(input logic [FREQ_W-1:0] f, input bit pin,
                            input quant_result_type pinned);
      if (!quiet && send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.freq_in <= f;
      pinned_valid    <= pin;
      pinned_result   <= pinned;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   // waits for the queue to empty, once the last accepted beat is queued
   task automatic wait_drained();
      @(posedge clock);
      while (due_notes.size() != 0) @(posedge clock);
   endtask

   function automatic logic [FREQ_W-1:0] pick_freq();
      case ($urandom_range(0, 9))
         0, 1:    return $urandom;
         2, 3, 4: return $urandom >> $urandom_range(0, 31);
         5, 6, 7: return half_step_floor(2 * $urandom_range(0, NOTE_TOP - 1) + 1)
                         + $urandom_range(0, 2) - 1;
         default: return note_value($urandom_range(0, NOTE_TOP))
                         + $urandom_range(0, 255) - 128;
      endcase
   endfunction

   initial begin : stimulus
      quant_result_type         pin;
      quant_result_type         none;
      logic [PC_COUNT-1:0]      mask;
      logic [3:0]               key;
      int                       beats;
      none              = '{default: '0};
      quiet             = 1'b0;
      send_gap_odds     = 4;
      scale_mask_now    = p2sq_pkg::SCALE_MASK_RESET;
      key_root_now      = p2sq_pkg::KEY_ROOT_RESET;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.freq_in   <= '0;
      csr_bus.valid     <= 1'b0;
      csr_bus.reg_index <= p2sq_pkg::REG_SCALE_MASK;
      csr_bus.wdata     <= '0;
      pinned_valid      <= 1'b0;
      pinned_result     <= none;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table at the reset scale (C major)
      foreach (tone_rows[i]) begin
         pin.freq_out = tone_rows[i].freq_out;
         pin.snapped  = tone_rows[i].snapped;
         pin.detected = tone_rows[i].detected;
         send_freq(tone_rows[i].freq, tone_rows[i].pinned, pin);
      end
      req_bus.valid <= 1'b0;
      wait_drained();

      // random phases, each under a new scale and key
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       begin mask = '0;                            key = 4'(KEY_COUNT - 1); end
            1:       begin mask = '1;                            key = '0;                end
            2:       begin mask = 12'h001;                       key = 4'(KEY_COUNT - 1); end
            3:       begin mask = 12'h800;                       key = '0;                end
            4:       begin mask = 12'h001 << $urandom_range(0, 11);
                           key = 4'($urandom_range(0, KEY_COUNT - 1));                   end
            default: begin mask = 12'($urandom);
                           key = 4'($urandom_range(0, KEY_COUNT - 1));                   end
         endcase
         csr_write(p2sq_pkg::REG_KEY_ROOT, {12'($urandom), key});
         csr_write(p2sq_pkg::REG_SCALE_MASK, {4'($urandom), mask});
         // writes the block must ignore: key out of range, unused index
         if ($urandom_range(0, 1) == 1)
            csr_write(p2sq_pkg::REG_KEY_ROOT,
                      {12'($urandom), 4'($urandom_range(KEY_COUNT, KEY_FIELD_MAX))});
         if ($urandom_range(0, 1) == 1)
            csr_write(CSR_INDEX_W'($urandom_range(p2sq_pkg::REG_KEY_ROOT + 1, INDEX_MAX)),
                      CSR_DATA_W'($urandom));
         csr_bus.valid <= 1'b0;

         quiet         = (p == PHASES - 1);
         send_gap_odds = (p % 3 == 2) ? 0 : ((p % 3 == 0) ? 3 : 10);
         beats         = quiet ? QUIET_BEATS : PHASE_BEATS;
         for (int n = 0; n < beats; n++) begin
            send_freq(pick_freq(), 1'b0, none);
         end
         req_bus.valid <= 1'b0;
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (due_notes.size() != 0) begin
         report_mismatch("beats never returned", due_notes.size(), 0);
      end
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
